/* src/ptsp_pkg.sv */
// Shared widths, codes and beat types of the point-to-segment projection core.
package ptsp_pkg;

  // Coordinate format and the widths that follow from it.
  localparam int unsigned CoordW  = 32;
  localparam int unsigned FracW   = 16;
  localparam int unsigned DiffW   = CoordW + 1;
  localparam int unsigned ProdW   = 2 * DiffW;
  localparam int unsigned DotW    = ProdW + 1;
  localparam int unsigned NumW    = ProdW + FracW;
  localparam int unsigned QuoW    = CoordW;
  localparam int unsigned RemW    = ProdW + 1;
  localparam int unsigned ClampW  = FracW + 1;
  localparam int unsigned LerpW   = DiffW + ClampW + 1;
  localparam int unsigned RootW   = ProdW / 2;
  localparam int unsigned SqRemW  = RootW + 4;
  localparam int unsigned CfgIdxW = 3;

  // One in the clamped index format, and the saturation limits of the raw index.
  localparam logic [ClampW-1:0] ClampOne = {1'b1, {FracW{1'b0}}};
  localparam logic [QuoW-1:0]   PosLim   = {1'b0, {(QuoW-1){1'b1}}};
  localparam logic [QuoW-1:0]   NegLim   = {1'b1, {(QuoW-1){1'b0}}};

  // Register indexes of the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CfgStartX = 3'd0,
    CfgStartY = 3'd1,
    CfgEndX   = 3'd2,
    CfgEndY   = 3'd3,
    CfgMinLen = 3'd4
  } cfg_reg_e;

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [DiffW-1:0]  diff_t;

  // Segment and query geometry carried along the pipeline.
  typedef struct packed {
    coord_t sx;
    coord_t sy;
    coord_t qx;
    coord_t qy;
    diff_t  dx;
    diff_t  dy;
  } geo_t;

  // State of one item inside the divider.
  typedef struct packed {
    geo_t             geo;
    logic             degen;
    logic             neg;
    logic             ovf;
    logic [ProdW-1:0] den;
    logic [ProdW-1:0] rem;
    logic [QuoW-1:0]  num_lo;
    logic [QuoW-1:0]  quo;
  } div_t;

  // One result beat.
  typedef struct packed {
    coord_t            raw_index;
    logic [ClampW-1:0] clamped_index;
    coord_t            closest_x;
    coord_t            closest_y;
    logic [CoordW-1:0] distance;
    logic              degenerate;
  } res_t;

  // State of one item inside the square root unit.
  typedef struct packed {
    res_t              res;
    logic [RootW-1:0]  root;
    logic [SqRemW-1:0] rem;
    logic [ProdW-1:0]  rad;
  } sq_t;

endpackage

/* src/ptsp_if.sv */
// Valid/ready channel interfaces for query and result beats.
interface ptsp_query_if import ptsp_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t query_x;
  coord_t query_y;

  modport source (output valid, output query_x, output query_y, input ready);
  modport sink (input valid, input query_x, input query_y, output ready);
endinterface

interface ptsp_result_if import ptsp_pkg::*; ();
  logic              valid;
  logic              ready;
  coord_t            raw_index;
  logic [ClampW-1:0] clamped_index;
  coord_t            closest_x;
  coord_t            closest_y;
  logic [CoordW-1:0] distance;
  logic              degenerate;

  modport source (output valid, output raw_index, output clamped_index, output closest_x,
                  output closest_y, output distance, output degenerate, input ready);
  modport sink (input valid, input raw_index, input clamped_index, input closest_x,
                input closest_y, input distance, input degenerate, output ready);
endinterface

/* src/ptsp_front.sv */
// Front stages: differences, products, squared length, dot product and divider setup.
module ptsp_front import ptsp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              in_valid_i,
  input  coord_t            qx_i,
  input  coord_t            qy_i,
  input  coord_t            sx_i,
  input  coord_t            sy_i,
  input  coord_t            ex_i,
  input  coord_t            ey_i,
  input  logic [CoordW-1:0] min_len_i,
  output logic              out_valid_o,
  output div_t              out_o
);

  typedef struct packed {
    geo_t             geo;
    diff_t            ux;
    diff_t            uy;
    logic [DiffW-1:0] minp1;
  } s1_t;

  typedef struct packed {
    geo_t                    geo;
    logic [ProdW-1:0]        dxx;
    logic [ProdW-1:0]        dyy;
    logic [ProdW-1:0]        msq;
    logic signed [ProdW-1:0] dxu;
    logic signed [ProdW-1:0] dyu;
  } s2_t;

  typedef struct packed {
    geo_t                   geo;
    logic [ProdW-1:0]       den;
    logic signed [DotW-1:0] dot;
    logic                   degen;
  } s3_t;

  typedef struct packed {
    geo_t             geo;
    logic [ProdW-1:0] den;
    logic             degen;
    logic             neg;
    logic [ProdW-1:0] mag;
  } s4_t;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  s4_t  s4_d, s4_q;
  div_t s5_d, s5_q;

  logic signed [ProdW-1:0] dxx_w, dyy_w, dxu_w, dyu_w;
  logic [ProdW-1:0]        msq_w;
  logic signed [DotW-1:0]  dot_w;
  logic signed [DotW-1:0]  dot_abs;
  logic [NumW-1:0]         num_w;
  logic [ProdW-1:0]        rem_init;

  // Stage 1: segment direction and query offset from the start.
  always_comb begin
    s1_d.geo.sx = sx_i;
    s1_d.geo.sy = sy_i;
    s1_d.geo.qx = qx_i;
    s1_d.geo.qy = qy_i;
    s1_d.geo.dx = DiffW'(ex_i) - DiffW'(sx_i);
    s1_d.geo.dy = DiffW'(ey_i) - DiffW'(sy_i);
    s1_d.ux     = DiffW'(qx_i) - DiffW'(sx_i);
    s1_d.uy     = DiffW'(qy_i) - DiffW'(sy_i);
    s1_d.minp1  = DiffW'(min_len_i) + DiffW'(1);
  end

  // Stage 2: the five products.
  assign dxx_w = s1_q.geo.dx * s1_q.geo.dx;
  assign dyy_w = s1_q.geo.dy * s1_q.geo.dy;
  assign dxu_w = s1_q.geo.dx * s1_q.ux;
  assign dyu_w = s1_q.geo.dy * s1_q.uy;
  assign msq_w = s1_q.minp1 * s1_q.minp1;

  always_comb begin
    s2_d.geo = s1_q.geo;
    s2_d.dxx = dxx_w;
    s2_d.dyy = dyy_w;
    s2_d.msq = msq_w;
    s2_d.dxu = dxu_w;
    s2_d.dyu = dyu_w;
  end

  // Stage 3: squared length, dot product and the degenerate test.
  // The floor of the length is at most min_length exactly when the squared
  // length is below (min_length + 1) squared.
  assign dot_w = s2_q.dxu + s2_q.dyu;

  always_comb begin
    s3_d.geo   = s2_q.geo;
    s3_d.den   = s2_q.dxx + s2_q.dyy;
    s3_d.dot   = dot_w;
    s3_d.degen = (s2_q.dxx + s2_q.dyy) < s2_q.msq;
  end

  // Stage 4: sign and magnitude of the dot product.
  assign dot_abs = s3_q.dot[DotW-1] ? -s3_q.dot : s3_q.dot;

  always_comb begin
    s4_d.geo   = s3_q.geo;
    s4_d.den   = s3_q.den;
    s4_d.degen = s3_q.degen;
    s4_d.neg   = s3_q.dot[DotW-1];
    s4_d.mag   = dot_abs[ProdW-1:0];
  end

  // Stage 5: dividend alignment and the quotient overflow check.
  assign num_w    = {s4_q.mag, {FracW{1'b0}}};
  assign rem_init = ProdW'(num_w[NumW-1:QuoW]);

  always_comb begin
    s5_d.geo    = s4_q.geo;
    s5_d.degen  = s4_q.degen;
    s5_d.neg    = s4_q.neg;
    s5_d.ovf    = rem_init >= s4_q.den;
    s5_d.den    = s4_q.den;
    s5_d.rem    = rem_init;
    s5_d.num_lo = num_w[QuoW-1:0];
    s5_d.quo    = '0;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      s5_q <= s5_d;
    end
  end

  assign out_valid_o = v5_q;
  assign out_o       = s5_q;

endmodule

/* src/ptsp_divider.sv */
// Pipelined restoring divider: one quotient bit per stage.
module ptsp_divider import ptsp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic in_valid_i,
  input  div_t in_i,
  output logic out_valid_o,
  output div_t out_o
);

  logic stage_v_in [QuoW];
  div_t stage_in   [QuoW];
  logic stage_v_q  [QuoW];
  div_t stage_q    [QuoW];

  assign stage_v_in[0] = in_valid_i;
  assign stage_in[0]   = in_i;

  for (genvar k = 0; k < QuoW; k++) begin : g_step
    logic [RemW-1:0] trial;
    logic [RemW-1:0] diff;
    logic            take;
    div_t            nxt;

    if (k > 0) begin : g_link
      assign stage_v_in[k] = stage_v_q[k-1];
      assign stage_in[k]   = stage_q[k-1];
    end

    // Shift in the next dividend bit and subtract the divisor if it fits.
    assign trial = {stage_in[k].rem, stage_in[k].num_lo[QuoW-1]};
    assign take  = trial >= {1'b0, stage_in[k].den};
    assign diff  = trial - {1'b0, stage_in[k].den};

    always_comb begin
      nxt        = stage_in[k];
      nxt.rem    = take ? diff[ProdW-1:0] : trial[ProdW-1:0];
      nxt.num_lo = {stage_in[k].num_lo[QuoW-2:0], 1'b0};
      nxt.quo    = {stage_in[k].quo[QuoW-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stage_v_q[k] <= 1'b0;
      end else if (en_i) begin
        stage_v_q[k] <= stage_v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[k] <= nxt;
      end
    end
  end

  assign out_valid_o = stage_v_q[QuoW-1];
  assign out_o       = stage_q[QuoW-1];

endmodule

/* src/ptsp_back.sv */
// Back stages: index saturation and clamp, interpolation and squared distance.
module ptsp_back import ptsp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic in_valid_i,
  input  div_t in_i,
  output logic out_valid_o,
  output sq_t  out_o
);

  typedef struct packed {
    geo_t              geo;
    coord_t            raw;
    logic [ClampW-1:0] clamped;
    logic              degen;
  } b1_t;

  typedef struct packed {
    b1_t                     idx;
    logic signed [LerpW-1:0] px;
    logic signed [LerpW-1:0] py;
  } b2_t;

  typedef struct packed {
    b1_t    idx;
    coord_t cx;
    coord_t cy;
    diff_t  ddx;
    diff_t  ddy;
  } b3_t;

  typedef struct packed {
    b1_t              idx;
    coord_t           cx;
    coord_t           cy;
    logic [ProdW-1:0] sqx;
    logic [ProdW-1:0] sqy;
  } b4_t;

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  b1_t  b1_d, b1_q;
  b2_t  b2_d, b2_q;
  b3_t  b3_d, b3_q;
  b4_t  b4_d, b4_q;
  sq_t  b5_d, b5_q;

  coord_t                  raw_w;
  logic signed [LerpW-1:0] px_w, py_w;
  logic signed [LerpW-1:0] sumx_w, sumy_w;
  coord_t                  cx_w, cy_w;
  logic signed [ProdW-1:0] sqx_w, sqy_w;

  // Stage 1: saturate the quotient to the signed range (zero if degenerate), then clamp to [0, 1].
  always_comb begin
    if (in_i.neg) begin
      if (in_i.ovf || (in_i.quo > NegLim)) begin
        raw_w = NegLim;
      end else begin
        raw_w = -in_i.quo;
      end
    end else begin
      if (in_i.ovf || (in_i.quo > PosLim)) begin
        raw_w = PosLim;
      end else begin
        raw_w = in_i.quo;
      end
    end
    if (in_i.degen) begin
      raw_w = '0;
    end
  end

  always_comb begin
    b1_d.geo   = in_i.geo;
    b1_d.raw   = raw_w;
    b1_d.degen = in_i.degen;
    priority if (raw_w[CoordW-1]) begin
      b1_d.clamped = '0;
    end else if (raw_w > CoordW'(ClampOne)) begin
      b1_d.clamped = ClampOne;
    end else begin
      b1_d.clamped = raw_w[ClampW-1:0];
    end
  end

  // Stage 2: scale the direction by the clamped index.
  assign px_w = b1_q.geo.dx * $signed({1'b0, b1_q.clamped});
  assign py_w = b1_q.geo.dy * $signed({1'b0, b1_q.clamped});

  always_comb begin
    b2_d.idx = b1_q;
    b2_d.px  = px_w;
    b2_d.py  = py_w;
  end

  // Stage 3: closest point (floor of the scaled step) and offset from the query.
  assign sumx_w = LerpW'(b2_q.idx.geo.sx) + (b2_q.px >>> FracW);
  assign sumy_w = LerpW'(b2_q.idx.geo.sy) + (b2_q.py >>> FracW);
  assign cx_w   = sumx_w[CoordW-1:0];
  assign cy_w   = sumy_w[CoordW-1:0];

  always_comb begin
    b3_d.idx = b2_q.idx;
    b3_d.cx  = cx_w;
    b3_d.cy  = cy_w;
    b3_d.ddx = DiffW'(b2_q.idx.geo.qx) - DiffW'(cx_w);
    b3_d.ddy = DiffW'(b2_q.idx.geo.qy) - DiffW'(cy_w);
  end

  // Stage 4: squares of the offset.
  assign sqx_w = b3_q.ddx * b3_q.ddx;
  assign sqy_w = b3_q.ddy * b3_q.ddy;

  always_comb begin
    b4_d.idx = b3_q.idx;
    b4_d.cx  = b3_q.cx;
    b4_d.cy  = b3_q.cy;
    b4_d.sqx = sqx_w;
    b4_d.sqy = sqy_w;
  end

  // Stage 5: squared distance and square root setup.
  always_comb begin
    b5_d.res.raw_index     = b4_q.idx.raw;
    b5_d.res.clamped_index = b4_q.idx.clamped;
    b5_d.res.closest_x     = b4_q.cx;
    b5_d.res.closest_y     = b4_q.cy;
    b5_d.res.distance      = '0;
    b5_d.res.degenerate    = b4_q.idx.degen;
    b5_d.root              = '0;
    b5_d.rem               = '0;
    b5_d.rad               = b4_q.sqx + b4_q.sqy;
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      b1_q <= b1_d;
      b2_q <= b2_d;
      b3_q <= b3_d;
      b4_q <= b4_d;
      b5_q <= b5_d;
    end
  end

  assign out_valid_o = v5_q;
  assign out_o       = b5_q;

endmodule

/* src/ptsp_sqrt.sv */
// Pipelined digit-by-digit square root: one root bit per stage.
module ptsp_sqrt import ptsp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic en_i,
  input  logic in_valid_i,
  input  sq_t  in_i,
  output logic out_valid_o,
  output sq_t  out_o
);

  logic stage_v_in [RootW];
  sq_t  stage_in   [RootW];
  logic stage_v_q  [RootW];
  sq_t  stage_q    [RootW];

  assign stage_v_in[0] = in_valid_i;
  assign stage_in[0]   = in_i;

  for (genvar k = 0; k < RootW; k++) begin : g_step
    logic [SqRemW-1:0] cur;
    logic [SqRemW-1:0] trial;
    logic [SqRemW-1:0] diff;
    logic              take;
    sq_t               nxt;

    if (k > 0) begin : g_link
      assign stage_v_in[k] = stage_v_q[k-1];
      assign stage_in[k]   = stage_q[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign cur   = {stage_in[k].rem[SqRemW-3:0], stage_in[k].rad[ProdW-1 -: 2]};
    assign trial = SqRemW'({stage_in[k].root, 2'b01});
    assign take  = cur >= trial;
    assign diff  = cur - trial;

    always_comb begin
      nxt      = stage_in[k];
      nxt.rem  = take ? diff : cur;
      nxt.root = {stage_in[k].root[RootW-2:0], take};
      nxt.rad  = {stage_in[k].rad[ProdW-3:0], 2'b00};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stage_v_q[k] <= 1'b0;
      end else if (en_i) begin
        stage_v_q[k] <= stage_v_in[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stage_q[k] <= nxt;
      end
    end
  end

  assign out_valid_o = stage_v_q[RootW-1];
  assign out_o       = stage_q[RootW-1];

endmodule

/* src/point_to_segment_projection_core.sv */
// Top level of the point-to-segment projection core.
//
//   channel  | direction | beat contents
//   ---------+-----------+----------------------------------------------------
//   query_i  | in        | query_x, query_y (signed Q16.16)
//   result_o | out       | raw_index, clamped_index, closest_x/y, distance,
//            |           | degenerate
//   cfg      | in        | cfg_we_i, cfg_idx_i, cfg_wdata_i (segment, min length)
//
// The pipeline has 5 front stages, 32 divider stages (one quotient bit each),
// 5 back stages and 33 square root stages (one root bit each).
// One query beat is accepted every cycle while the skid buffer is empty.
// Reset clears the valid bits, the skid buffer and the segment registers.
// A stalled result is parked in a one-entry skid buffer; while it is full
// the whole pipeline holds and query_i.ready is low.
module point_to_segment_projection_core import ptsp_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  ptsp_query_if.sink         query_i,
  ptsp_result_if.source      result_o,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CoordW-1:0]  cfg_wdata_i
);

  coord_t            start_x_q, start_y_q, end_x_q, end_y_q;
  logic [CoordW-1:0] min_len_q;

  logic en;
  logic front_v, div_v, back_v, sq_v;
  div_t front_out, div_out;
  sq_t  back_out, sq_out;
  res_t fin;
  res_t out_data;
  logic skid_v_d, skid_v_q;
  res_t skid_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
      end_x_q   <= '0;
      end_y_q   <= '0;
      min_len_q <= CoordW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgStartX: start_x_q <= cfg_wdata_i;
        CfgStartY: start_y_q <= cfg_wdata_i;
        CfgEndX:   end_x_q   <= cfg_wdata_i;
        CfgEndY:   end_y_q   <= cfg_wdata_i;
        CfgMinLen: min_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // The pipeline advances whenever the skid buffer is empty.
  assign en            = !skid_v_q;
  assign query_i.ready = en;

  ptsp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (query_i.valid),
    .qx_i        (query_i.query_x),
    .qy_i        (query_i.query_y),
    .sx_i        (start_x_q),
    .sy_i        (start_y_q),
    .ex_i        (end_x_q),
    .ey_i        (end_y_q),
    .min_len_i   (min_len_q),
    .out_valid_o (front_v),
    .out_o       (front_out)
  );

  ptsp_divider u_divider (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (front_v),
    .in_i        (front_out),
    .out_valid_o (div_v),
    .out_o       (div_out)
  );

  ptsp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (div_v),
    .in_i        (div_out),
    .out_valid_o (back_v),
    .out_o       (back_out)
  );

  ptsp_sqrt u_sqrt (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (back_v),
    .in_i        (back_out),
    .out_valid_o (sq_v),
    .out_o       (sq_out)
  );

  // Saturate the distance to the coordinate width.
  always_comb begin
    fin          = sq_out.res;
    fin.distance = (|sq_out.root[RootW-1:CoordW]) ? '1 : sq_out.root[CoordW-1:0];
  end

  // Skid buffer: holds the oldest result while the sink stalls.
  always_comb begin
    if (skid_v_q) begin
      skid_v_d = !result_o.ready;
    end else begin
      skid_v_d = sq_v && !result_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q && sq_v && !result_o.ready) begin
      skid_q <= fin;
    end
  end

  // Result channel.
  assign out_data               = skid_v_q ? skid_q : fin;
  assign result_o.valid         = skid_v_q || sq_v;
  assign result_o.raw_index     = out_data.raw_index;
  assign result_o.clamped_index = out_data.clamped_index;
  assign result_o.closest_x     = out_data.closest_x;
  assign result_o.closest_y     = out_data.closest_y;
  assign result_o.distance      = out_data.distance;
  assign result_o.degenerate    = out_data.degenerate;

endmodule

/* src/ptsp_checker.sv */
// Port-level checks of the projection core and their bind to the top level.
module ptsp_checker import ptsp_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              q_ready_i,
  input logic              r_valid_i,
  input logic              r_ready_i,
  input coord_t            raw_index_i,
  input logic [ClampW-1:0] clamped_index_i,
  input logic              degenerate_i
);

  // A stalled result beat is not withdrawn.
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid_i && !r_ready_i |=> r_valid_i)
    else $error("result beat withdrawn while stalled");

  // The input side only closes after the sink stalled a result.
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(q_ready_i) |-> $past(r_valid_i && !r_ready_i))
    else $error("query ready dropped without an output stall");

  // A degenerate segment reports a zero index.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid_i && degenerate_i |-> (raw_index_i == '0) && (clamped_index_i == '0))
    else $error("degenerate result with nonzero index");

  // The clamped index never exceeds one.
  a_clamp_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid_i |-> clamped_index_i <= ClampOne)
    else $error("clamped index above one");

  // Inside [0, 1] the clamped index equals the raw index.
  a_clamp_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    r_valid_i && !raw_index_i[CoordW-1] && (raw_index_i <= CoordW'(ClampOne))
      |-> CoordW'(clamped_index_i) == raw_index_i)
    else $error("clamped index differs from raw index inside range");

endmodule

bind point_to_segment_projection_core ptsp_checker u_ptsp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .q_ready_i       (query_i.ready),
  .r_valid_i       (result_o.valid),
  .r_ready_i       (result_o.ready),
  .raw_index_i     (result_o.raw_index),
  .clamped_index_i (result_o.clamped_index),
  .degenerate_i    (result_o.degenerate)
);

/* tb/sv/point_to_segment_projection_core_tb.sv */
// Self-checking testbench of the point-to-segment projection core.
`timescale 1ns / 100ps

module point_to_segment_projection_core_tb;
  import ptsp_pkg::*;

  localparam int unsigned PipeLatency = 75;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned NumPhases   = 7;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned HoldCycles  = 300;
  localparam logic [31:0] CoordMax    = 32'h7FFF_FFFF;
  localparam logic [31:0] CoordMin    = 32'h8000_0000;

  // One row of the directed part: a register write or a query beat.
  typedef struct {
    bit          is_cfg;
    cfg_reg_e    idx;
    logic [31:0] wdata;
    coord_t      qx;
    coord_t      qy;
    bit          typed;
    res_t        want;
  } row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CoordW-1:0]  cfg_wdata;

  ptsp_query_if  query_if ();
  ptsp_result_if result_if ();

  point_to_segment_projection_core uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .query_i    (query_if),
    .result_o   (result_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  // Segment registers as the core should hold them.
  coord_t      seg_sx, seg_sy, seg_ex, seg_ey;
  logic [31:0] seg_min;

  res_t        pending_results[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          hold_req;
  bit          hold_done;

  // Clock and cycle limit.
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Floor of the square root of a 128-bit value.
  function automatic logic [127:0] isqrt(input logic [127:0] n);
    logic [127:0] res;
    logic [127:0] b;
    res = '0;
    b = 128'd1 << 126;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Expected result of one query against the current segment.
  function automatic res_t project_point(input coord_t qx, input coord_t qy);
    logic signed [127:0] sx, sy, ex, ey, px, py, dx, dy, len2, dot, mag, quo;
    logic signed [127:0] raw, cx, cy, ddx, ddy;
    logic signed [127:0] lim;
    logic [127:0] length, dist_val;
    logic degen;
    logic [16:0] clamp;
    res_t r;
    lim = 128'sd2147483648;
    sx = seg_sx; sy = seg_sy; ex = seg_ex; ey = seg_ey; px = qx; py = qy;
    dx = ex - sx;
    dy = ey - sy;
    len2 = dx * dx + dy * dy;
    length = isqrt(len2);
    degen = length <= {96'b0, seg_min};
    raw = '0; clamp = '0; cx = sx; cy = sy;
    if (!degen) begin
      dot = dx * (px - sx) + dy * (py - sy);
      mag = (dot < 0) ? -dot : dot;
      quo = (mag <<< FracW) / len2;
      if (dot < 0) raw = (quo > lim) ? -lim : -quo;
      else raw = (quo > lim - 1) ? lim - 1 : quo;
      if (raw < 0) clamp = '0;
      else if (raw > 65536) clamp = ClampOne;
      else clamp = raw[16:0];
      // Floor rounding toward minus infinity keeps the point on the segment.
      cx = sx + ((dx * $signed({1'b0, clamp})) >>> FracW);
      cy = sy + ((dy * $signed({1'b0, clamp})) >>> FracW);
    end
    ddx = px - cx;
    ddy = py - cy;
    dist_val = isqrt(ddx * ddx + ddy * ddy);
    if (dist_val > 128'hFFFF_FFFF) dist_val = 128'hFFFF_FFFF;
    r.raw_index = raw[31:0];
    r.clamped_index = clamp;
    r.closest_x = cx[31:0];
    r.closest_y = cy[31:0];
    r.distance = dist_val[31:0];
    r.degenerate = degen;
    return r;
  endfunction

  // Result checker: every beat taken is compared with the oldest prediction.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && result_if.valid && result_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result beat with no prediction pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (result_if.raw_index !== want.raw_index) begin
          $error("raw_index: expected %h, got %h", want.raw_index, result_if.raw_index);
          fail_count++;
        end
        if (result_if.clamped_index !== want.clamped_index) begin
          $error("clamped_index: expected %h, got %h", want.clamped_index,
                 result_if.clamped_index);
          fail_count++;
        end
        if (result_if.closest_x !== want.closest_x) begin
          $error("closest_x: expected %h, got %h", want.closest_x, result_if.closest_x);
          fail_count++;
        end
        if (result_if.closest_y !== want.closest_y) begin
          $error("closest_y: expected %h, got %h", want.closest_y, result_if.closest_y);
          fail_count++;
        end
        if (result_if.distance !== want.distance) begin
          $error("distance: expected %h, got %h", want.distance, result_if.distance);
          fail_count++;
        end
        if (result_if.degenerate !== want.degenerate) begin
          $error("degenerate: expected %b, got %b", want.degenerate, result_if.degenerate);
          fail_count++;
        end
      end
    end
  end

  // Random gap length: mostly short, now and then long.
  function automatic int unsigned gap_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random stalls, plus one long hold-off when asked for.
  initial begin
    int unsigned n;
    result_if.ready = 1'b0;
    hold_done = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        result_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_done = 1'b1;
      end
      n = gap_len();
      if (n == 0) begin
        result_if.ready <= 1'b1;
      end else begin
        result_if.ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Write one register; starts and ends at a falling edge.
  task automatic cfg_write(input cfg_reg_e idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    case (idx)
      CfgStartX: seg_sx = data;
      CfgStartY: seg_sy = data;
      CfgEndX:   seg_ex = data;
      CfgEndY:   seg_ey = data;
      CfgMinLen: seg_min = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Let the pipeline run empty before touching the registers.
  task automatic drain();
    query_if.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (PipeLatency + 5) @(negedge clk);
  endtask

  // Offer one query beat until it is taken; starts and ends at a falling edge.
  task automatic send_query(input coord_t qx, input coord_t qy, input bit typed,
                            input res_t want);
    query_if.valid <= 1'b1;
    query_if.query_x <= qx;
    query_if.query_y <= qy;
    do @(posedge clk); while (!query_if.ready);
    pending_results.push_back(typed ? want : project_point(qx, qy));
    @(negedge clk);
  endtask

  // Random gap on the query side; the valid stays up when there is none.
  task automatic query_gap();
    int unsigned n;
    n = gap_len();
    if (n != 0) begin
      query_if.valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_coord(input int unsigned mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
      default: begin
        case ($urandom_range(0, 2))
          0: return CoordMin;
          1: return CoordMax;
          default: return '0;
        endcase
      end
    endcase
  endfunction

  function automatic logic [31:0] pick_min_len();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 262144);
      default: return $urandom();
    endcase
  endfunction

  // Stimulus.
  initial begin
    row_t rows[$];
    res_t none;
    int unsigned mode;
    logic [31:0] sx, sy;
    coord_t qx, qy;

    none = '0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    query_if.valid = 1'b0;
    query_if.query_x = '0;
    query_if.query_y = '0;
    hold_req = 1'b0;
    fail_count = 0;
    cycle_count = 0;
    seg_sx = '0; seg_sy = '0; seg_ex = '0; seg_ey = '0; seg_min = 32'd1;

    // Directed part, starting from the reset segment (a point at the origin).
    rows.push_back('{0, CfgStartX, 0, 0, 0, 1, '{0, 0, 0, 0, 0, 1}});
    rows.push_back('{0, CfgStartX, 0, 32'h3_0000, 32'h4_0000, 1,
                     '{0, 0, 0, 0, 32'h5_0000, 1}});
    rows.push_back('{0, CfgStartX, 0, -32'sh3_0000, -32'sh4_0000, 1,
                     '{0, 0, 0, 0, 32'h5_0000, 1}});
    rows.push_back('{0, CfgStartX, 0, CoordMax, CoordMax, 0, none});
    rows.push_back('{0, CfgStartX, 0, CoordMin, CoordMin, 0, none});
    // Horizontal segment of length ten.
    rows.push_back('{1, CfgEndX, 32'hA_0000, 0, 0, 0, none});
    rows.push_back('{0, CfgStartX, 0, 32'h5_0000, 32'h3_0000, 1,
                     '{32'h8000, 17'h8000, 32'h5_0000, 0, 32'h3_0000, 0}});
    rows.push_back('{0, CfgStartX, 0, -32'sh5_0000, 0, 1,
                     '{32'hFFFF_8000, 0, 0, 0, 32'h5_0000, 0}});
    rows.push_back('{0, CfgStartX, 0, 32'h14_0000, 0, 1,
                     '{32'h2_0000, ClampOne, 32'hA_0000, 0, 32'hA_0000, 0}});
    rows.push_back('{0, CfgStartX, 0, 32'hA_0000, 0, 1,
                     '{32'h1_0000, ClampOne, 32'hA_0000, 0, 0, 0}});
    rows.push_back('{0, CfgStartX, 0, CoordMax, CoordMin, 0, none});
    // Tiny segment: the raw index saturates both ways.
    rows.push_back('{1, CfgEndX, 32'd2, 0, 0, 0, none});
    rows.push_back('{1, CfgMinLen, 32'd0, 0, 0, 0, none});
    rows.push_back('{0, CfgStartX, 0, CoordMax, 0, 1,
                     '{PosLim, ClampOne, 32'd2, 0, 32'd2147483645, 0}});
    rows.push_back('{0, CfgStartX, 0, CoordMin, 0, 1,
                     '{NegLim, 0, 0, 0, 32'h8000_0000, 0}});
    // Length equal to the minimum is degenerate, one above it is not.
    rows.push_back('{1, CfgMinLen, 32'd2, 0, 0, 0, none});
    rows.push_back('{0, CfgStartX, 0, 32'h1_0000, 0, 1, '{0, 0, 0, 0, 32'h1_0000, 1}});
    rows.push_back('{1, CfgMinLen, 32'd1, 0, 0, 0, none});
    rows.push_back('{0, CfgStartX, 0, 32'h1_0000, 0, 0, none});
    // Longest possible segment, corner to corner.
    rows.push_back('{1, CfgStartX, CoordMin, 0, 0, 0, none});
    rows.push_back('{1, CfgStartY, CoordMin, 0, 0, 0, none});
    rows.push_back('{1, CfgEndX, CoordMax, 0, 0, 0, none});
    rows.push_back('{1, CfgEndY, CoordMax, 0, 0, 0, none});
    rows.push_back('{1, CfgMinLen, 32'hFFFF_FFFF, 0, 0, 0, none});
    rows.push_back('{0, CfgStartX, 0, 0, 0, 0, none});
    rows.push_back('{0, CfgStartX, 0, CoordMax, CoordMin, 0, none});
    rows.push_back('{0, CfgStartX, 0, CoordMin, CoordMax, 0, none});
    rows.push_back('{0, CfgStartX, 0, CoordMax, CoordMax, 0, none});

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        drain();
        cfg_write(rows[i].idx, rows[i].wdata);
      end else begin
        send_query(rows[i].qx, rows[i].qy, rows[i].typed, rows[i].want);
        query_gap();
      end
    end

    // Random part: a fresh segment per phase, queries spread and close by.
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      drain();
      mode = $urandom_range(0, 3);
      sx = pick_coord(mode == 3 ? 0 : mode);
      sy = pick_coord(mode == 3 ? 0 : mode);
      cfg_write(CfgStartX, sx);
      cfg_write(CfgStartY, sy);
      if (mode == 3) begin
        // Mostly degenerate: end sits on or right next to the start.
        cfg_write(CfgEndX, sx + $urandom_range(0, 3));
        cfg_write(CfgEndY, sy);
      end else begin
        cfg_write(CfgEndX, pick_coord(mode));
        cfg_write(CfgEndY, pick_coord(mode));
      end
      cfg_write(CfgMinLen, pick_min_len());
      if (ph == 1) hold_req = 1'b1;
      for (int unsigned k = 0; k < PhaseItems; k++) begin
        if ($urandom_range(0, 1) == 0) begin
          qx = $urandom();
          qy = $urandom();
        end else begin
          qx = seg_sx + 32'($signed($urandom_range(0, 8388608)) - 4194304);
          qy = seg_sy + 32'($signed($urandom_range(0, 8388608)) - 4194304);
        end
        send_query(qx, qy, 1'b0, none);
        query_gap();
      end
    end

    query_if.valid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (PipeLatency + 20) @(negedge clk);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* point_to_segment_projection_core.f */
src/ptsp_pkg.sv
src/ptsp_if.sv
src/ptsp_front.sv
src/ptsp_divider.sv
src/ptsp_back.sv
src/ptsp_sqrt.sv
src/point_to_segment_projection_core.sv
src/ptsp_checker.sv
tb/sv/point_to_segment_projection_core_tb.sv
